[rtl/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg: shared types and binary32 arithmetic helpers
// Control struct for the cell chain, and the functions that decode, align
// and round binary32 operands with round to nearest even.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // Request codes
    localparam logic [1:0] ACT_WRITE_A = 2'd0;
    localparam logic [1:0] ACT_WRITE_B = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Per-cycle controls broadcast to every cell
    typedef struct packed {
        logic mul_en;
        logic rnd_en;
        logic add_en;
        logic acc_en;
        logic clear;
        logic shift;
    } t_cell_ctl;

    // Raw product: value = m * 2^(e - 150)
    typedef struct packed {
        logic               s;
        logic signed [11:0] e;
        logic [47:0]        m;
        logic               nan;
        logic               inf;
    } t_prod;

    // Aligned sum: value = m * 2^(e - 150)
    typedef struct packed {
        logic               s;
        logic signed [11:0] e;
        logic [27:0]        m;
        logic               nan;
        logic               inf;
    } t_sum;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    // Significand with hidden bit, subnormals kept
    function automatic logic [23:0] sig_of(input logic [31:0] x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

    // Biased exponent, subnormals read as one
    function automatic logic [7:0] exp_of(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    endfunction

    // Exact product of two binary32 values before rounding
    function automatic t_prod fp_mul_raw(input logic [31:0] a, input logic [31:0] b);
        t_prod r;
        logic  za;
        logic  zb;
        za    = (a[30:0] == 31'd0);
        zb    = (b[30:0] == 31'd0);
        r.s   = a[31] ^ b[31];
        r.m   = 48'(sig_of(a)) * 48'(sig_of(b));
        r.e   = $signed(12'(exp_of(a))) + $signed(12'(exp_of(b))) - 12'sd150;
        r.nan = is_nan(a) || is_nan(b) || (is_inf(a) && zb) || (is_inf(b) && za);
        r.inf = is_inf(a) || is_inf(b);
        return r;
    endfunction

    // Align and add two binary32 values, three guard bits plus sticky jam
    function automatic t_sum fp_add_raw(input logic [31:0] x, input logic [31:0] y);
        t_sum        r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  d;
        logic [26:0] sm;
        logic [26:0] sh;
        logic        jam;
        logic [27:0] mb;
        if (x[30:0] >= y[30:0]) begin
            big = x;
            sml = y;
        end else begin
            big = y;
            sml = x;
        end
        d  = exp_of(big) - exp_of(sml);
        sm = {sig_of(sml), 3'b000};
        if (d >= 8'd27) begin
            sh  = 27'd0;
            jam = (sm != 27'd0);
        end else begin
            sh  = sm >> d;
            jam = ((sm & ((27'd1 << d) - 27'd1)) != 27'd0);
        end
        mb = {1'b0, sig_of(big), 3'b000};
        if (x[31] == y[31]) begin
            r.m = mb + {1'b0, sh | 27'(jam)};
        end else begin
            r.m = mb - {1'b0, sh | 27'(jam)};
        end
        r.s   = (r.m == 28'd0) ? (x[31] & y[31]) : big[31];
        r.e   = $signed(12'(exp_of(big))) - 12'sd3;
        r.nan = is_nan(x) || is_nan(y) || (is_inf(x) && is_inf(y) && (x[31] != y[31]));
        r.inf = is_inf(x) || is_inf(y);
        if (r.inf && !r.nan) begin
            r.s = is_inf(x) ? x[31] : y[31];
        end
        return r;
    endfunction

    // Round m * 2^(e - 150) to binary32, nearest even, subnormals kept
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [47:0] m);
        int          p;
        int          er;
        int          sh;
        logic [63:0] mm;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        logic        inc;
        p   = 0;
        inc = 1'b0;
        mm  = {16'd0, m};
        for (int i = 0; i < 48; i++) begin
            if (m[i]) p = i;
        end
        er = p + int'(e) - 23;
        if (m == 48'd0) return {s, 31'd0};
        if (er > 254) return {s, 8'hFF, 23'd0};
        sh = (er >= 1) ? (p - 23) : (1 - int'(e));
        if (sh > 60) sh = 60;
        if (sh <= 0) begin
            q = mm << (-sh);
        end else begin
            q    = mm >> sh;
            rem  = mm & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            inc  = (rem > half) || ((rem == half) && q[0]);
        end
        bits = (64'((er >= 1) ? (er - 1) : 0) << 23) + q + 64'(inc);
        if (bits >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
        return {s, bits[30:0]};
    endfunction

endpackage

[rtl/smm_cell.sv]
// ----------------------------------------------------------------------------
// smm_cell: one column of the result row
// Holds its own column of B, multiplies the broadcast A element by the B
// element of the current k, rounds, and adds into a running sum; the sums
// shift towards cell zero for output.
// ----------------------------------------------------------------------------
module smm_cell
    import smm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_b_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_b_wr_addr,
    input  logic [31:0]              i_b_wr_data,
    input  logic                     i_b_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_b_rd_addr,
    input  logic [31:0]              i_a,
    input  logic [31:0]              i_next_sum,
    output logic [31:0]              o_sum
);

    logic [31:0] r_mem_b [DEPTH];
    logic [31:0] r_b;
    t_prod       r_prod_raw;
    logic [31:0] r_prod;
    t_sum        r_sum_raw;
    logic [31:0] r_sum;

    // Column store of B: element writes, registered read of row k
    always_ff @(posedge i_clk) begin
        if (i_b_wr_en) begin
            r_mem_b[i_b_wr_addr] <= i_b_wr_data;
        end
        if (i_b_rd_en) begin
            r_b <= r_mem_b[i_b_rd_addr];
        end
    end

    // Multiply significands
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod_raw <= fp_mul_raw(i_a, r_b);
        end
    end

    // Round the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.rnd_en) begin
            if (r_prod_raw.nan) begin
                r_prod <= CANON_NAN;
            end else if (r_prod_raw.inf) begin
                r_prod <= {r_prod_raw.s, 8'hFF, 23'd0};
            end else begin
                r_prod <= fp_round(r_prod_raw.s, r_prod_raw.e, r_prod_raw.m);
            end
        end
    end

    // Align and add against the running sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en) begin
            r_sum_raw <= fp_add_raw(r_sum, r_prod);
        end
    end

    // Clear, accumulate or shift the running sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= 32'd0;
        end else if (i_ctl.shift) begin
            r_sum <= i_next_sum;
        end else if (i_ctl.acc_en) begin
            if (r_sum_raw.nan) begin
                r_sum <= CANON_NAN;
            end else if (r_sum_raw.inf) begin
                r_sum <= {r_sum_raw.s, 8'hFF, 23'd0};
            end else begin
                r_sum <= fp_round(r_sum_raw.s, r_sum_raw.e, {20'd0, r_sum_raw.m});
            end
        end
    end

    assign o_sum = r_sum;

endmodule

[rtl/square_matrix_multiply_core.sv]
// ----------------------------------------------------------------------------
// square_matrix_multiply_core: binary32 matrix product, one row per request
// Write requests are accepted whenever the block is idle. A compute request
// steps through k in turn, each step paced by the add-and-round loop in
// each cell, then gives N results, one per cycle while the sink accepts;
// no new request is taken until the last result of the row has gone out.
// Reset clears the control state and sets the order to 32; the matrix
// stores are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core
    import smm_pkg::*;
#(
    parameter int MAX_ORDER = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_row,
    input  logic [4:0]  i_col,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_out_row,
    output logic [4:0]  o_out_col,
    output logic [31:0] o_result_value,
    output logic        o_last
);

    localparam int IW  = $clog2(MAX_ORDER);
    localparam int AW  = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int LIM = (MAX_ORDER < 32) ? MAX_ORDER : 32;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]    r_state;
    logic [5:0]    r_size;
    logic [4:0]    r_row;
    logic [4:0]    r_k;
    logic [4:0]    r_col;
    logic          r_ph;
    logic [3:0]    r_v;
    logic [31:0]   r_a;
    logic [31:0]   r_mem_a [MAX_ORDER * MAX_ORDER];
    logic [31:0]   w_sum   [MAX_ORDER + 1];
    logic [5:0]    w_n;
    logic [4:0]    w_nm1;
    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_start;
    logic          w_issue;
    logic          w_b_wr;
    logic [IW-1:0] w_b_wr_addr;
    logic [IW-1:0] w_b_rd_addr;
    t_cell_ctl     w_ctl;

    // Effective order, clamped to the supported range
    assign w_n   = (r_size == 6'd0) ? 6'd1 : ((r_size > 6'(LIM)) ? 6'(LIM) : r_size);
    assign w_nm1 = 5'(w_n - 6'd1);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = o_out_valid && i_out_ready;
    assign w_start    = w_in_acc && (i_action == ACT_COMPUTE) && ({1'b0, i_row} < w_n);
    assign w_issue    = (r_state == ST_RUN) && !r_ph;

    // B element writes go to the cell of their column
    assign w_b_wr      = w_in_acc && (i_action == ACT_WRITE_B)
                         && (int'(i_row) < MAX_ORDER) && (int'(i_col) < MAX_ORDER);
    assign w_b_wr_addr = IW'(i_row);
    assign w_b_rd_addr = IW'(r_k);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 6'd32;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // Sequence one request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= 5'd0;
            r_col   <= 5'd0;
            r_ph    <= 1'b0;
            r_v     <= 4'd0;
            r_row   <= 5'd0;
        end else begin
            r_v <= {r_v[2:0], w_issue};
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_RUN;
                        r_row   <= i_row;
                        r_k     <= 5'd0;
                        r_ph    <= 1'b0;
                        r_col   <= 5'd0;
                    end
                end
                ST_RUN: begin
                    r_ph <= !r_ph;
                    if (w_issue) begin
                        r_k <= r_k + 5'd1;
                        if (r_k == w_nm1) begin
                            r_state <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (r_v == 4'd0) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_acc) begin
                        r_col <= r_col + 5'd1;
                        if (r_col == w_nm1) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Store of A: element writes, registered read of A[i][k]
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_action == ACT_WRITE_A)
                && (int'(i_row) < MAX_ORDER) && (int'(i_col) < MAX_ORDER)) begin
            r_mem_a[AW'(int'(i_row) * MAX_ORDER + int'(i_col))] <= i_value;
        end
        if (w_issue) begin
            r_a <= r_mem_a[AW'(int'(r_row) * MAX_ORDER + int'(r_k))];
        end
    end

    // Broadcast controls
    always_comb begin
        w_ctl.mul_en = r_v[0];
        w_ctl.rnd_en = r_v[1];
        w_ctl.add_en = r_v[2];
        w_ctl.acc_en = r_v[3];
        w_ctl.clear  = w_start;
        w_ctl.shift  = w_out_acc;
    end

    // Chain of column cells, sums drain towards cell zero
    assign w_sum[MAX_ORDER] = 32'd0;
    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
        smm_cell #(
            .DEPTH (MAX_ORDER)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_b_wr_en   (w_b_wr && (int'(i_col) == j)),
            .i_b_wr_addr (w_b_wr_addr),
            .i_b_wr_data (i_value),
            .i_b_rd_en   (w_issue),
            .i_b_rd_addr (w_b_rd_addr),
            .i_a         (r_a),
            .i_next_sum  (w_sum[j + 1]),
            .o_sum       (w_sum[j])
        );
    end

    assign o_out_valid    = (r_state == ST_OUT);
    assign o_out_row      = r_row;
    assign o_out_col      = r_col;
    assign o_result_value = w_sum[0];
    assign o_last         = (r_col == w_nm1);

endmodule

[dv/tb_square_matrix_multiply_core.sv]
// ----------------------------------------------------------------------------
// tb_square_matrix_multiply_core: self-checking bench for the matrix core
// Loads A and B through the request channel, asks for result rows and checks
// every element against an integer-exact binary32 predictor (separately
// rounded multiply and add, nearest even). Runs several matrix orders,
// including the clamped extremes, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply_core;
    import smm_pkg::*;

    localparam int          ORDER_CAP  = 32;
    localparam int          CYCLE_CAP  = 1500000;
    localparam int          SETTLE     = 2 * ORDER_CAP + 20;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  action;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] value;
    } t_req;

    typedef struct {
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] value;
        logic        last;
    } t_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [5:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [4:0]  i_row;
    logic [4:0]  i_col;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_out_row;
    logic [4:0]  o_out_col;
    logic [31:0] o_result_value;
    logic        o_last;

    t_req        pending_reqs[$];
    t_elem       expected_elems[$];
    logic [31:0] a_mirror[0:1023];
    logic [31:0] b_mirror[0:1023];
    bit          a_loaded[0:1023];
    bit          b_loaded[0:1023];
    logic [5:0]  size_mirror;
    int          idle_mode;
    int          hold_cycles;
    int          cycle_cnt;
    bit          failed;

    square_matrix_multiply_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // binary32 arithmetic, exact in integers then rounded once
    // ------------------------------------------------------------------------

    // Round m * 2^e to binary32, nearest even, subnormals kept
    function automatic logic [31:0] round_single(input logic s, input logic [127:0] m,
                                                 input int e);
        int           msb;
        int           biased;
        int           sh;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        logic         inc;
        logic [63:0]  bits;
        if (m == 128'd0) return {s, 31'd0};
        msb = 0;
        for (int i = 0; i < 128; i++) begin
            if (m[i]) msb = i;
        end
        biased = msb + e + 127;
        if (biased > 254) return {s, 8'hFF, 23'd0};
        sh  = (biased >= 1) ? (msb - 23) : (-149 - e);
        inc = 1'b0;
        if (sh >= 127) return {s, 31'd0};
        if (sh <= 0) begin
            q = m << (-sh);
        end else begin
            q    = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            inc  = (rem > half) || ((rem == half) && q[0]);
        end
        bits = ((biased >= 1) ? (64'(biased - 1) << 23) : 64'd0) + q[63:0] + 64'(inc);
        if (bits >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
        return {s, bits[30:0]};
    endfunction

    function automatic bit nan_bits(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic bit inf_bits(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 0);
    endfunction

    // Significand and power of two of a finite value
    function automatic logic [23:0] mant(input logic [31:0] x);
        return {(x[30:23] != 0), x[22:0]};
    endfunction

    function automatic int pow2(input logic [31:0] x);
        return ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
    endfunction

    function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (nan_bits(a) || nan_bits(b)) return CANON_NAN;
        if ((inf_bits(a) && b[30:0] == 0) || (inf_bits(b) && a[30:0] == 0))
            return CANON_NAN;
        if (inf_bits(a) || inf_bits(b)) return {s, 8'hFF, 23'd0};
        return round_single(s, 128'(mant(a)) * 128'(mant(b)), pow2(a) + pow2(b));
    endfunction

    function automatic logic [31:0] single_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0]  hi;
        logic [31:0]  lo;
        logic [127:0] big;
        logic [127:0] tiny;
        logic [127:0] mag;
        logic         s;
        int           d;
        int           e;
        if (nan_bits(x) || nan_bits(y)) return CANON_NAN;
        if (inf_bits(x) && inf_bits(y) && x[31] != y[31]) return CANON_NAN;
        if (inf_bits(x)) return x;
        if (inf_bits(y)) return y;
        if (pow2(x) >= pow2(y)) begin
            hi = x;
            lo = y;
        end else begin
            hi = y;
            lo = x;
        end
        d = pow2(hi) - pow2(lo);
        // Far below the larger operand the smaller one only acts as a sticky bit
        if (d > 60) begin
            big  = 128'(mant(hi)) << 60;
            tiny = (mant(lo) != 0) ? 128'd1 : 128'd0;
            e    = pow2(hi) - 60;
        end else begin
            big  = 128'(mant(hi)) << d;
            tiny = 128'(mant(lo));
            e    = pow2(lo);
        end
        if (hi[31] == lo[31]) begin
            mag = big + tiny;
            s   = hi[31];
        end else if (big >= tiny) begin
            mag = big - tiny;
            s   = hi[31];
        end else begin
            mag = tiny - big;
            s   = lo[31];
        end
        if (mag == 0) s = x[31] & y[31];
        return round_single(s, mag, e);
    endfunction

    function automatic int order_in_use();
        int n;
        n = int'(size_mirror);
        if (n < 1) n = 1;
        if (n > ORDER_CAP) n = ORDER_CAP;
        return n;
    endfunction

    // Apply one accepted request to the mirrors and queue the row it yields
    function automatic void predict_request(input t_req r);
        int          n;
        logic [31:0] acc;
        t_elem       el;
        n = order_in_use();
        case (r.action)
            ACT_WRITE_A: a_mirror[{r.row, r.col}] = r.value;
            ACT_WRITE_B: b_mirror[{r.row, r.col}] = r.value;
            ACT_COMPUTE: begin
                if (int'(r.row) < n) begin
                    for (int j = 0; j < n; j++) begin
                        acc = 32'd0;
                        for (int k = 0; k < n; k++) begin
                            acc = single_add(acc, single_mul(a_mirror[r.row * 32 + k],
                                                             b_mirror[k * 32 + j]));
                        end
                        el.row   = r.row;
                        el.col   = 5'(j);
                        el.value = nan_bits(acc) ? CANON_NAN : acc;
                        el.last  = (j == n - 1);
                        expected_elems.push_back(el);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic   take;
        int     idle_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take     = 1'b0;
            idle_pct = (idle_mode == 0) ? 16 : ((idle_mode == 1) ? 69 : 0);
            // Retire the accepted request
            if (i_in_valid && o_in_ready) begin
                predict_request(pending_reqs.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                take = 1'b1;
            end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                take     = 1'b1;
                i_action <= pending_reqs[0].action;
                i_row    <= pending_reqs[0].row;
                i_col    <= pending_reqs[0].col;
                i_value  <= pending_reqs[0].value;
            end
            i_in_valid <= take;
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_elem want;
        int    stall_pct;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_pct = (idle_mode == 0) ? 69 : ((idle_mode == 1) ? 16 : 0);
            if (o_out_valid && i_out_ready) begin
                if (expected_elems.size() == 0) begin
                    $display("%0t unexpected result row %0d col %0d value %08h last %0b",
                             $time, o_out_row, o_out_col, o_result_value, o_last);
                    failed = 1'b1;
                end else begin
                    want = expected_elems.pop_front();
                    if (o_out_row !== want.row) begin
                        $display("%0t out_row expected %0d actual %0d",
                                 $time, want.row, o_out_row);
                        failed = 1'b1;
                    end
                    if (o_out_col !== want.col) begin
                        $display("%0t out_col expected %0d actual %0d",
                                 $time, want.col, o_out_col);
                        failed = 1'b1;
                    end
                    if (o_result_value !== want.value) begin
                        $display("%0t result_value (%0d,%0d) expected %08h actual %08h",
                                 $time, want.row, want.col, want.value, o_result_value);
                        failed = 1'b1;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t last expected %0b actual %0b",
                                 $time, want.last, o_last);
                        failed = 1'b1;
                    end
                end
            end
            i_out_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                case ($urandom_range(0, 6))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = {v[31], 8'hFF, 23'd0};
                    3: v = {v[31], 8'hFF, v[22:0] | 23'd1};
                    4: v = {v[31], 8'h00, v[22:0]};
                    5: v = {v[31], 31'h7F7F_FFFF};
                    default: v = {v[31], 8'h01, 23'd0};
                endcase
            end
            default: v[30:23] = 8'($urandom_range(118, 136));
        endcase
        return v;
    endfunction

    function automatic void queue_req(input logic [1:0] act, input int row, input int col,
                                      input logic [31:0] val);
        t_req r;
        r.action = act;
        r.row    = 5'(row);
        r.col    = 5'(col);
        r.value  = val;
        pending_reqs.push_back(r);
        if (act == ACT_WRITE_A) a_loaded[row * 32 + col] = 1'b1;
        if (act == ACT_WRITE_B) b_loaded[row * 32 + col] = 1'b1;
    endfunction

    // Load whatever a row request would read that was never written
    function automatic void cover_row(input int row);
        int n;
        n = order_in_use();
        for (int k = 0; k < n; k++) begin
            if (!a_loaded[row * 32 + k]) queue_req(ACT_WRITE_A, row, k, pick_value());
            for (int j = 0; j < n; j++) begin
                if (!b_loaded[k * 32 + j]) queue_req(ACT_WRITE_B, k, j, pick_value());
            end
        end
    endfunction

    function automatic void queue_row(input int row);
        if (row < order_in_use()) cover_row(row);
        queue_req(ACT_COMPUTE, row, $urandom_range(0, 31), $urandom());
    endfunction

    function automatic void queue_mix(input int count);
        int n;
        int pick;
        n = order_in_use();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                queue_req(($urandom_range(0, 1) == 0) ? ACT_WRITE_A : ACT_WRITE_B,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1),
                          pick_value());
            end else if (pick < 18) begin
                queue_row(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1));
            end else begin
                queue_req(ACT_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom());
            end
        end
    endfunction

    // Wait for every request to go in and every result to come out
    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_elems.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_order(input logic [5:0] sz);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= sz;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        size_mirror = sz;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 6'd0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_action      = ACT_WRITE_A;
        i_row         = 5'd0;
        i_col         = 5'd0;
        i_value       = 32'd0;
        size_mirror   = 6'd32;
        idle_mode     = 0;
        hold_cycles   = 0;
        cycle_cnt     = 0;
        failed        = 1'b0;
        for (int i = 0; i < 1024; i++) begin
            a_mirror[i] = 32'd0;
            b_mirror[i] = 32'd0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Order from reset: writes at the top of the store and an unused code
        queue_req(ACT_WRITE_A, 31, 31, pick_value());
        queue_req(ACT_WRITE_B, 31, 0, pick_value());
        queue_req(ACT_UNUSED, 0, 0, 32'h0);
        drain();

        // Directed: order two with infinities, NaN, signed zero and subnormals
        set_order(6'd2);
        queue_req(ACT_WRITE_A, 0, 0, 32'h7F7F_FFFF);
        queue_req(ACT_WRITE_A, 0, 1, 32'h3F80_0000);
        queue_req(ACT_WRITE_A, 1, 0, 32'h0000_0001);
        queue_req(ACT_WRITE_A, 1, 1, 32'h8000_0000);
        queue_req(ACT_WRITE_B, 0, 0, 32'h4000_0000);
        queue_req(ACT_WRITE_B, 0, 1, 32'h7F80_0000);
        queue_req(ACT_WRITE_B, 1, 0, 32'hFF80_0000);
        queue_req(ACT_WRITE_B, 1, 1, 32'h7FC0_0001);
        queue_req(ACT_COMPUTE, 0, 31, 32'hFFFF_FFFF);
        queue_req(ACT_COMPUTE, 1, 0, 32'h0);
        // Rounding ties in the subnormal range and a cancelling negative zero
        queue_req(ACT_WRITE_A, 1, 1, 32'h0000_0001);
        queue_req(ACT_WRITE_B, 0, 0, 32'h3F00_0000);
        queue_req(ACT_WRITE_B, 1, 0, 32'h3F40_0000);
        queue_req(ACT_WRITE_A, 0, 0, 32'h8000_0000);
        queue_req(ACT_WRITE_A, 0, 1, 32'h8000_0000);
        queue_req(ACT_WRITE_B, 0, 1, 32'h3F80_0000);
        queue_req(ACT_WRITE_B, 1, 1, 32'hBF80_0000);
        queue_req(ACT_COMPUTE, 1, 0, 32'h0);
        queue_req(ACT_COMPUTE, 0, 0, 32'h0);
        // Row beyond the order, unused code, writes outside the order
        queue_req(ACT_COMPUTE, 2, 0, 32'h0);
        queue_req(ACT_COMPUTE, 31, 31, 32'hFFFF_FFFF);
        queue_req(ACT_UNUSED, 31, 31, 32'hFFFF_FFFF);
        queue_req(ACT_WRITE_A, 31, 31, 32'hFFFF_FFFF);
        queue_req(ACT_WRITE_B, 31, 31, 32'h0000_0000);
        drain();

        // Size zero clamps to one
        set_order(6'd0);
        queue_mix(15);
        drain();

        set_order(6'd1);
        queue_mix(15);
        drain();

        // Mid-phase pause: sender waits for the last result
        set_order(6'd4);
        queue_mix(10);
        drain();
        queue_mix(10);
        drain();

        // Receiver holds off while the sender keeps offering rows
        idle_mode = 1;
        set_order(6'd4);
        hold_cycles = 400;
        for (int i = 0; i < 6; i++) queue_row(i % 4);
        queue_mix(12);
        drain();

        // Size above the cap clamps to the top order
        set_order(6'd63);
        queue_req(ACT_WRITE_A, 30, 31, pick_value());
        queue_req(ACT_WRITE_B, 31, 30, pick_value());
        queue_req(ACT_UNUSED, 5, 5, 32'hFFFF_FFFF);
        drain();

        idle_mode = 2;
        set_order(6'd3);
        queue_mix(25);
        drain();

        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
